/* design/ws2812fs_pkg.sv */
// Shared types, codes and defaults for the WS2812 frame serializer.
package ws2812fs_pkg;

    localparam int LED_COUNT_DEF   = 96;
    localparam int RESET_SLOTS_DEF = 48;

    localparam int DUTY_W      = 8;
    localparam int COLOUR_W    = 24;
    localparam int CFG_INDEX_W = 1;

    localparam logic [DUTY_W-1:0] HIGH_DUTY_RST = 8'd60;
    localparam logic [DUTY_W-1:0] LOW_DUTY_RST  = 8'd30;

    // input word kinds
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    // status codes
    localparam logic [1:0] STATUS_READY = 2'd0;
    localparam logic [1:0] STATUS_BUSY  = 2'd1;
    localparam logic [1:0] STATUS_ERROR = 2'd2;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_HIGH_DUTY = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOW_DUTY  = 1'd1;

    // colour byte order on the wire
    localparam logic [1:0] COL_GREEN = 2'd0;
    localparam logic [1:0] COL_RED   = 2'd1;
    localparam logic [1:0] COL_BLUE  = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [9:0] position;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } in_word_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [DUTY_W-1:0] duty;
        logic              frame_end;
    } out_word_t;

endpackage

/* design/ws2812fs_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module ws2812fs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 96,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/ws2812_frame_serializer.sv */
// WS2812 frame serializer: colour store, slot sequencer and duty output stage.
//
// Usage: words arrive on s_valid/s_ready/s_word. A write word stores
// red, green and blue at a position (an out-of-range position sets the error
// status), a start word begins a frame when idle and error free, and a tick
// word asks for the PWM compare value of the next bit slot. Slots run green,
// red, blue of each LED, MSB first, then RESET_SLOTS zero slots; frame_end
// marks the last slot. Every input word gives exactly one result word on
// m_valid/m_ready/m_word.
// Throughput: one word per cycle while m_ready is high. A word is registered
// first in the stage register, beside the registered read of the colour RAM,
// then in the output register that drives m_valid.
// Reset: idle, no error, store reads as all zero (per-entry valid bits), duties 60
// and 30. The user writes duties on the cfg port while idle; the block does not enforce it.
// Stall: with m_ready low the two pipeline words hold and s_ready drops
// once both are full; nothing is lost.
module ws2812_frame_serializer import ws2812fs_pkg::*; #(
    parameter int LED_COUNT   = LED_COUNT_DEF,
    parameter int RESET_SLOTS = RESET_SLOTS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_word_t               s_word,
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_word_t              m_word,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [DUTY_W-1:0]      cfg_wdata
);

    localparam int LED_W   = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam int TRAIL_W = $clog2(RESET_SLOTS);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_DATA  = 3'b010,
        ST_TRAIL = 3'b100
    } seq_state_t;

    typedef struct packed {
        logic       data_slot;
        logic [1:0] byte_sel;
        logic [2:0] bit_sel;
        logic       entry_ok;
        logic [1:0] status;
        logic       frame_end;
    } slot_info_t;

    seq_state_t state_reg, state_next;
    logic [LED_W-1:0]   led_reg, led_next;
    logic [1:0]         byte_reg, byte_next;
    logic [2:0]         bit_reg, bit_next;
    logic [TRAIL_W-1:0] trail_reg, trail_next;
    logic               error_reg, error_next;
    logic [LED_COUNT-1:0] entry_valid_reg;
    logic [DUTY_W-1:0]  high_duty_reg, low_duty_reg;

    slot_info_t s1_reg, s1_next;
    logic       s1_valid_reg;
    out_word_t  out_reg, out_next;
    logic       m_valid_reg;

    logic       accept, advance_out, frame_end;
    logic       pos_ok, wr_en, rd_en;
    logic [COLOUR_W-1:0] rd_data;
    logic [7:0] colour_byte;
    logic       bit_val;

    assign advance_out = !m_valid_reg || m_ready;
    assign s_ready     = !s1_valid_reg || advance_out;
    assign accept      = s_valid && s_ready;
    assign pos_ok      = {1'b0, s_word.position} < 11'(LED_COUNT);
    assign wr_en       = accept && (s_word.kind == KIND_WRITE) && pos_ok;
    assign rd_en       = accept && (s_word.kind == KIND_TICK) && (state_reg == ST_DATA);

    ws2812fs_ram #(
        .WIDTH (COLOUR_W),
        .DEPTH (LED_COUNT),
        .ADDR_W(LED_W)
    ) u_colour_ram (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(s_word.position[LED_W-1:0]),
        .wr_data({s_word.red, s_word.green, s_word.blue}),
        .rd_en  (rd_en),
        .rd_addr(led_reg),
        .rd_data(rd_data)
    );

    // slot sequencer
    always_comb begin
        state_next = state_reg;
        led_next   = led_reg;
        byte_next  = byte_reg;
        bit_next   = bit_reg;
        trail_next = trail_reg;
        error_next = error_reg;
        frame_end  = 1'b0;
        case (s_word.kind)
            KIND_WRITE: begin
                error_next = !pos_ok;
            end
            KIND_START: begin
                if (state_reg == ST_IDLE && !error_reg) begin
                    state_next = ST_DATA;
                    led_next   = '0;
                    byte_next  = COL_GREEN;
                    bit_next   = '0;
                    trail_next = '0;
                end
            end
            KIND_TICK: begin
                case (state_reg)
                    ST_DATA: begin
                        bit_next = bit_reg + 3'd1;
                        if (bit_reg == 3'd7) begin
                            if (byte_reg == COL_BLUE) begin
                                byte_next = COL_GREEN;
                                if (led_reg == LED_W'(LED_COUNT - 1)) begin
                                    state_next = ST_TRAIL;
                                    trail_next = '0;
                                end else begin
                                    led_next = led_reg + LED_W'(1);
                                end
                            end else begin
                                byte_next = byte_reg + 2'd1;
                            end
                        end
                    end
                    ST_TRAIL: begin
                        if (trail_reg == TRAIL_W'(RESET_SLOTS - 1)) begin
                            frame_end  = 1'b1;
                            state_next = ST_IDLE;
                            trail_next = '0;
                        end else begin
                            trail_next = trail_reg + TRAIL_W'(1);
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        s1_next.data_slot = (s_word.kind == KIND_TICK) && (state_reg == ST_DATA);
        s1_next.byte_sel  = byte_reg;
        s1_next.bit_sel   = bit_reg;
        s1_next.entry_ok  = entry_valid_reg[led_reg];
        s1_next.frame_end = frame_end;
        if (state_next != ST_IDLE) begin
            s1_next.status = STATUS_BUSY;
        end else if (error_next) begin
            s1_next.status = STATUS_ERROR;
        end else begin
            s1_next.status = STATUS_READY;
        end
    end

    // duty pick from the RAM word
    always_comb begin
        case (s1_reg.byte_sel)
            COL_GREEN: colour_byte = rd_data[15:8];
            COL_RED:   colour_byte = rd_data[23:16];
            default:   colour_byte = rd_data[7:0];
        endcase
        bit_val            = colour_byte[3'd7 - s1_reg.bit_sel] && s1_reg.entry_ok;
        out_next.status    = s1_reg.status;
        out_next.frame_end = s1_reg.frame_end;
        if (!s1_reg.data_slot) begin
            out_next.duty = '0;
        end else if (bit_val) begin
            out_next.duty = high_duty_reg;
        end else begin
            out_next.duty = low_duty_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            led_reg         <= '0;
            byte_reg        <= COL_GREEN;
            bit_reg         <= '0;
            trail_reg       <= '0;
            error_reg       <= 1'b0;
            entry_valid_reg <= '0;
            high_duty_reg   <= HIGH_DUTY_RST;
            low_duty_reg    <= LOW_DUTY_RST;
            s1_valid_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (accept) begin
                state_reg <= state_next;
                led_reg   <= led_next;
                byte_reg  <= byte_next;
                bit_reg   <= bit_next;
                trail_reg <= trail_next;
                error_reg <= error_next;
            end
            if (wr_en) begin
                entry_valid_reg[s_word.position[LED_W-1:0]] <= 1'b1;
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_HIGH_DUTY: high_duty_reg <= cfg_wdata;
                    CFG_LOW_DUTY:  low_duty_reg  <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (s_ready) begin
                s1_valid_reg <= s_valid;
            end
            if (advance_out) begin
                m_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_reg <= s1_next;
        end
        if (advance_out && s1_valid_reg) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_word  = out_reg;

endmodule

/* tb/ws2812_frame_serializer_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the WS2812 frame serializer: directed, full-frame and random words.
module ws2812_frame_serializer_test;
    import ws2812fs_pkg::*;

    localparam int LEDS        = LED_COUNT_DEF;
    localparam int GAP_SLOTS   = RESET_SLOTS_DEF;
    localparam int DATA_SLOTS  = LEDS * 24;
    localparam int FRAME_SLOTS = DATA_SLOTS + GAP_SLOTS;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    in_word_t               s_word    = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    out_word_t              m_word;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [DUTY_W-1:0]      cfg_wdata = '0;

    ws2812_frame_serializer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_word    (s_word),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_word    (m_word),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // serializer state as predicted
    logic [COLOUR_W-1:0] pixel_mem [LEDS];
    int unsigned         slot_pos  = 0;
    bit                  frame_on  = 1'b0;
    bit                  bad_write = 1'b0;
    logic [DUTY_W-1:0]   duty_one  = HIGH_DUTY_RST;
    logic [DUTY_W-1:0]   duty_zero = LOW_DUTY_RST;

    out_word_t awaited_out[$];
    int        fail_count = 0;
    bit        tx_live    = 1'b0;
    bit        tx_steady  = 1'b0;
    bit        rx_steady  = 1'b0;

    function automatic out_word_t next_out_word(input in_word_t w);
        out_word_t         r;
        int unsigned       slot_in_led;
        logic [1:0]        col;
        logic [COLOUR_W-1:0] px;
        logic [7:0]        colour_byte;
        r = '0;
        case (w.kind)
            KIND_WRITE: begin
                if (w.position < LEDS) begin
                    pixel_mem[w.position] = {w.red, w.green, w.blue};
                    bad_write = 1'b0;
                end else begin
                    bad_write = 1'b1;
                end
            end
            KIND_START: begin
                if (!frame_on && !bad_write) begin
                    frame_on = 1'b1;
                    slot_pos = 0;
                end
            end
            KIND_TICK: begin
                if (frame_on) begin
                    if (slot_pos < DATA_SLOTS) begin
                        px          = pixel_mem[slot_pos / 24];
                        slot_in_led = slot_pos % 24;
                        col         = 2'(slot_in_led / 8);
                        case (col)
                            COL_GREEN: colour_byte = px[15:8];
                            COL_RED:   colour_byte = px[23:16];
                            default:   colour_byte = px[7:0];
                        endcase
                        r.duty = colour_byte[7 - slot_in_led % 8] ? duty_one : duty_zero;
                    end
                    if (slot_pos + 1 >= FRAME_SLOTS) begin
                        r.frame_end = 1'b1;
                        frame_on    = 1'b0;
                        slot_pos    = 0;
                    end else begin
                        slot_pos++;
                    end
                end
            end
            default: ;
        endcase
        r.status = frame_on ? STATUS_BUSY : (bad_write ? STATUS_ERROR : STATUS_READY);
        return r;
    endfunction

    function automatic int rand_gap(input bit steady);
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] rand_byte();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return 8'h00;
        if (r == 1)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic in_word_t make_word(input logic [1:0] kind);
        in_word_t w;
        w.kind     = kind;
        w.position = 10'($urandom_range(0, 1023));
        w.red      = 8'($urandom_range(0, 255));
        w.green    = 8'($urandom_range(0, 255));
        w.blue     = 8'($urandom_range(0, 255));
        return w;
    endfunction

    function automatic in_word_t make_write(input logic [9:0] pos, input logic [7:0] r,
                                            input logic [7:0] g, input logic [7:0] b);
        in_word_t w;
        w.kind     = KIND_WRITE;
        w.position = pos;
        w.red      = r;
        w.green    = g;
        w.blue     = b;
        return w;
    endfunction

    function automatic in_word_t rand_write(input bit in_range);
        logic [9:0] pos;
        pos = in_range ? 10'($urandom_range(0, LEDS - 1)) : 10'($urandom_range(LEDS, 1023));
        return make_write(pos, rand_byte(), rand_byte(), rand_byte());
    endfunction

    task automatic send_word(input in_word_t w);
        int gap;
        gap = rand_gap(tx_steady);
        if (gap > 0) begin
            if (tx_live)
                s_valid <= 1'b0;
            tx_live = 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_word  <= w;
        tx_live = 1'b1;
        do @(posedge aclk); while (!s_ready);
        awaited_out.push_back(next_out_word(w));
    endtask

    task automatic release_input();
        if (tx_live)
            s_valid <= 1'b0;
        tx_live = 1'b0;
    endtask

    task automatic wait_drained();
        release_input();
        while (awaited_out.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic finish_frame();
        while (frame_on)
            send_word(make_word(KIND_TICK));
    endtask

    // only called with the pipeline empty and no frame running
    task automatic set_duties(input logic [7:0] hi, input logic [7:0] lo);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_HIGH_DUTY;
        cfg_wdata <= hi;
        @(posedge aclk);
        cfg_index <= CFG_LOW_DUTY;
        cfg_wdata <= lo;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        duty_one  = hi;
        duty_zero = lo;
        @(posedge aclk);
    endtask

    task automatic test_directed();
        send_word(make_word(KIND_TICK));
        send_word(make_word(KIND_UNUSED));
        send_word(make_write(10'd0, 8'hFF, 8'h00, 8'hFF));
        send_word(make_write(10'(LEDS - 1), 8'h00, 8'hFF, 8'h00));
        send_word(make_write(10'(LEDS), 8'h12, 8'h34, 8'h56));
        send_word(make_word(KIND_START));
        send_word(make_write(10'h3FF, 8'hAA, 8'h55, 8'h80));
        send_word(make_word(KIND_TICK));
        send_word(make_write(10'd1, 8'h80, 8'h01, 8'h7F));
        send_word(make_word(KIND_START));
        send_word(make_word(KIND_START));
        repeat (8) send_word(make_word(KIND_TICK));
        send_word(make_write(10'd0, 8'h00, 8'h00, 8'h00));
        send_word(make_write(10'd2, 8'h0F, 8'hF0, 8'h3C));
        send_word(make_write(10'(LEDS + 5), 8'hFF, 8'hFF, 8'hFF));
        send_word(make_word(KIND_UNUSED));
        send_word(make_write(10'd3, 8'hC3, 8'h81, 8'h18));
    endtask

    // the open frame runs to its last slot with other words mixed in
    task automatic test_frames();
        int r;
        bit dropped;
        dropped = 1'b0;
        if (!frame_on)
            send_word(make_word(KIND_START));
        while (frame_on) begin
            r = $urandom_range(0, 99);
            if (!dropped && slot_pos > DATA_SLOTS / 2) begin
                // frame should close with the error status
                send_word(rand_write(1'b0));
                dropped = 1'b1;
            end else if (r < 2 && !dropped) begin
                send_word(rand_write(1'b1));
            end else if (r == 2) begin
                send_word(make_word(KIND_START));
            end else if (r == 3) begin
                send_word(make_word(KIND_UNUSED));
            end else begin
                send_word(make_word(KIND_TICK));
            end
        end
    endtask

    task automatic test_random();
        int r;
        finish_frame();
        wait_drained();
        set_duties(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        for (int n = 0; n < 450; n++) begin
            if (n % 50 == 0)
                tx_steady = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 50)
                send_word(make_word(KIND_TICK));
            else if (r < 72)
                send_word(rand_write(1'b1));
            else if (r < 78)
                send_word(rand_write(1'b0));
            else if (r < 93)
                send_word(make_word(KIND_START));
            else
                send_word(make_word(KIND_UNUSED));
        end
        tx_steady = 1'b0;
    endtask

    initial begin
        foreach (pixel_mem[i])
            pixel_mem[i] = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_frames();
        test_random();
        wait_drained();
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // result side back-pressure
    initial begin
        int stall;
        while (!aresetn)
            @(posedge aclk);
        forever begin
            if ($urandom_range(0, 49) == 0)
                rx_steady = !rx_steady;
            stall = rand_gap(rx_steady);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_out.size() == 0) begin
                $display("%0t: unexpected word, expected none, got %h", $time, m_word);
                fail_count++;
            end else begin
                want = awaited_out.pop_front();
                if (m_word.status !== want.status) begin
                    $display("%0t: status expected %0d got %0d", $time, want.status,
                             m_word.status);
                    fail_count++;
                end
                if (m_word.duty !== want.duty) begin
                    $display("%0t: duty expected %0d got %0d", $time, want.duty, m_word.duty);
                    fail_count++;
                end
                if (m_word.frame_end !== want.frame_end) begin
                    $display("%0t: frame_end expected %0b got %0b", $time, want.frame_end,
                             m_word.frame_end);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
